// ===== hw/rtl/tap_tempo_estimator_macros.svh =====
// Assertion macros shared by the tap tempo checker.
`ifndef TAP_TEMPO_ESTIMATOR_MACROS_SVH
`define TAP_TEMPO_ESTIMATOR_MACROS_SVH

// Checked only while out of reset.
`define TTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define TTE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/tte_pkg.sv =====
// Shared constants and controller/datapath types of the tap tempo estimator.
`default_nettype none

package tte_pkg;

    localparam int TAP_SLOTS      = 4;
    localparam int SLOT_W         = $clog2(TAP_SLOTS);
    localparam int WALK_INTERVALS = ((TAP_SLOTS - 1) < 3) ? (TAP_SLOTS - 1) : 3;
    localparam int STEP_W         = 2;
    localparam int COUNT_W        = 2;

    localparam int TIME_W         = 32;
    localparam int TIMEOUT_W      = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

    localparam int SUM_W          = TIME_W + 2;
    localparam int TEMPO_W        = 20;
    localparam logic [TEMPO_W-1:0] TEMPO_SAT = 20'd600000;

    localparam int DIVIDEND_W     = SUM_W;
    localparam int DIVISOR_W      = TIME_W;
    localparam int DIV_STEPS      = DIVIDEND_W;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam logic [DIVIDEND_W-1:0] TEMPO_DIVIDEND = 34'd600000;

    localparam int M_TDATA_W      = 24;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_WALK      = 5'b00010,
        ST_DIV_AVG   = 5'b00100,
        ST_DIV_TEMPO = 5'b01000,
        ST_DONE      = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_tap;
        logic walk_step;
        logic div_start;
        logic div_sel_tempo;
        logic tempo_sat;
        logic tempo_div;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic sum_zero;
        logic div_done;
        logic quot_zero;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tte_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module tte_div
    import tte_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // partial remainder stays below the divisor, so its low bits suffice
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tte_dp.sv =====
// Datapath: tap ring, interval walk, shared divider and output register.
`default_nettype none

module tte_dp
    import tte_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire logic [TIME_W-1:0]     tap_time,
    input  wire logic                  cfg_valid,
    input  wire logic [TIMEOUT_W-1:0]  cfg_data,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [M_TDATA_W-1:0]       m_tdata
);

    logic [TIME_W-1:0]    ring_reg [TAP_SLOTS];
    logic [SLOT_W-1:0]    wslot_reg;
    logic [TIME_W-1:0]    last_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic [SLOT_W-1:0]    pos_reg;
    logic [TIME_W-1:0]    newer_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [STEP_W-1:0]    step_reg;

    logic [TEMPO_W-1:0]   tempo_reg;
    logic                 m_valid_reg;
    logic [TEMPO_W-1:0]   m_tempo_reg;
    logic [COUNT_W-1:0]   m_used_reg;

    logic [TIME_W-1:0]    gap;
    logic                 clear;
    logic [SLOT_W-1:0]    store_slot;
    logic [SLOT_W-1:0]    slot_after;
    logic [SLOT_W-1:0]    pos_prev;
    logic [TIME_W-1:0]    older;
    logic [TIME_W-1:0]    interval;

    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] quotient;

    // wrap is modulo 2^32, so a plain subtract gives the gap
    assign gap        = tap_time - last_reg;
    assign clear      = gap > {{(TIME_W - TIMEOUT_W){1'b0}}, timeout_reg};
    assign store_slot = clear ? '0 : wslot_reg;
    assign slot_after = (store_slot == SLOT_W'(TAP_SLOTS - 1)) ? '0 : store_slot + 1'b1;

    assign pos_prev = (pos_reg == '0) ? SLOT_W'(TAP_SLOTS - 1) : pos_reg - 1'b1;
    assign older    = ring_reg[pos_prev];
    assign interval = newer_reg - older;

    assign status.walk_done = (step_reg == STEP_W'(WALK_INTERVALS)) ||
                              (newer_reg == '0) || (older == '0);
    assign status.sum_zero  = sum_reg == '0;
    assign status.div_done  = div_done;
    assign status.quot_zero = quotient[DIVISOR_W-1:0] == '0;
    assign status.out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAP_SLOTS; i++) begin
                ring_reg[i] <= '0;
            end
            wslot_reg   <= '0;
            last_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
            if (cmd.load_tap) begin
                for (int i = 0; i < TAP_SLOTS; i++) begin
                    if (SLOT_W'(i) == store_slot) begin
                        ring_reg[i] <= tap_time;
                    end else if (clear) begin
                        ring_reg[i] <= '0;
                    end
                end
                wslot_reg <= slot_after;
                last_reg  <= tap_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_tap) begin
            pos_reg   <= store_slot;
            newer_reg <= tap_time;
            sum_reg   <= '0;
            count_reg <= '0;
            step_reg  <= '0;
        end else if (cmd.walk_step) begin
            pos_reg   <= pos_prev;
            newer_reg <= older;
            sum_reg   <= sum_reg + {{(SUM_W - TIME_W){1'b0}}, interval};
            count_reg <= count_reg + 1'b1;
            step_reg  <= step_reg + 1'b1;
        end
        if (cmd.tempo_sat) begin
            tempo_reg <= TEMPO_SAT;
        end else if (cmd.tempo_div) begin
            tempo_reg <= quotient[TEMPO_W-1:0];
        end
        if (cmd.out_load) begin
            m_tempo_reg <= tempo_reg;
            m_used_reg  <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // first pass: sum / count; second pass: 600000 / average (still in quotient)
    assign div_dividend = cmd.div_sel_tempo ? TEMPO_DIVIDEND : sum_reg;
    assign div_divisor  = cmd.div_sel_tempo ? quotient[DIVISOR_W-1:0]
                                            : {{(DIVISOR_W - COUNT_W){1'b0}}, count_reg};

    tte_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - TEMPO_W - COUNT_W){1'b0}}, m_used_reg, m_tempo_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/tte_ctrl.sv =====
// Controller: sequences tap store, interval walk and the two divisions.
`default_nettype none

module tte_ctrl
    import tte_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       playing,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                // a tap while playing is taken and dropped
                if (s_tvalid && !playing) begin
                    cmd.load_tap = 1'b1;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (status.walk_done) begin
                    if (status.sum_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV_AVG;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_DIV_AVG: begin
                if (status.div_done) begin
                    if (status.quot_zero) begin
                        cmd.tempo_sat = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        cmd.div_start     = 1'b1;
                        cmd.div_sel_tempo = 1'b1;
                        state_next        = ST_DIV_TEMPO;
                    end
                end
            end
            ST_DIV_TEMPO: begin
                if (status.div_done) begin
                    cmd.tempo_div = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tap_tempo_estimator.sv =====
// A tap beat is stored and up to 3 intervals are walked and summed; the serial divider
// then runs sum / count and 600000 / average (a zero average skips the second pass and
// saturates the tempo), and the result waits until the output register is free. Taps
// while playing or giving no tempo end early. s_tready is low until the controller is idle
// again, so a new tap waits; the divider (one quotient bit per cycle, 34 bits) sets the pace.
// Reset (aresetn low, synchronous): tap ring, write slot and last time cleared,
// timeout back to 2000 ms, output beat dropped.
`default_nettype none

module tap_tempo_estimator
    import tte_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TIME_W-1:0]     s_tdata,   // [31:0] time_ms
    input  wire logic                  s_tuser,   // [0] playing
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [19:0] tempo_tenths, [21:20] intervals_used
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [TIMEOUT_W-1:0]  cfg_data   // [15:0] tap_timeout_ms
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .playing  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tte_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .tap_time  (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tte_checker.sv =====
// Port-level checker for the tap tempo estimator, bound to the top level.
`default_nettype none
`include "tap_tempo_estimator_macros.svh"

module tte_checker
    import tte_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    `TTE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `TTE_ASSERT(a_tempo_range, m_tvalid |-> m_tdata[19:0] <= TEMPO_SAT, "tempo above saturation")
    `TTE_ASSERT(a_used_nonzero, m_tvalid |-> m_tdata[21:20] != 2'd0, "result with no intervals")
    `TTE_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[23:22] == 2'd0, "tdata padding not zero")
    `TTE_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result beat survives reset")

endmodule

bind tap_tempo_estimator tte_checker u_tte_checker (.*);

`default_nettype wire
